// ----- design/lewc_pkg.sv -----
// Package for the line editor with cursor.
// Holds the sequencer state type, key classes, register indexes and character codes.
// No dependencies.
`default_nettype none
package lewc_pkg;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int CHAR_W = 8;
  localparam int MOVE_W = 7;

  localparam logic [1:0] REG_LEFT  = 2'd0;
  localparam logic [1:0] REG_RIGHT = 2'd1;
  localparam logic [1:0] REG_UP    = 2'd2;
  localparam logic [1:0] REG_DOWN  = 2'd3;

  localparam logic [CHAR_W-1:0] CH_NL = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BS = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SP = 8'd32;

  localparam logic [CHAR_W-1:0] RST_LEFT  = 8'd128;
  localparam logic [CHAR_W-1:0] RST_RIGHT = 8'd129;
  localparam logic [CHAR_W-1:0] RST_UP    = 8'd130;
  localparam logic [CHAR_W-1:0] RST_DOWN  = 8'd131;

  localparam logic [MOVE_W-1:0] MOVE_NONE = 7'h00;
  localparam logic [MOVE_W-1:0] MOVE_BACK = 7'h7F;
  localparam logic [MOVE_W-1:0] MOVE_FWD  = 7'h01;

  typedef enum logic [2:0] {
    KEY_PRINT,
    KEY_ENTER,
    KEY_BS,
    KEY_LEFT,
    KEY_RIGHT,
    KEY_IGNORE
  } lewc_key_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOVE,
    ST_INS_RD,
    ST_INS_WR,
    ST_BS_RD,
    ST_BS_WR,
    ST_BS_END,
    ST_NL,
    ST_LN_RD,
    ST_LN_WR
  } lewc_state_t;

endpackage
`default_nettype wire

// ----- design/lewc_cfg.sv -----
// Configuration registers of the line editor and key classification.
// APB-style register file for the four arrow codes; depends on lewc_pkg.
`default_nettype none
module lewc_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lewc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [lewc_pkg::DATA_W-1:0] pwdata,
  output logic      [lewc_pkg::DATA_W-1:0] prdata,
  input  wire logic [lewc_pkg::CHAR_W-1:0] key_code,
  output lewc_pkg::lewc_key_t              kind
);

  logic [lewc_pkg::CHAR_W-1:0] left_code;
  logic [lewc_pkg::CHAR_W-1:0] right_code;
  logic [lewc_pkg::CHAR_W-1:0] up_code;
  logic [lewc_pkg::CHAR_W-1:0] down_code;
  logic [1:0]                  reg_sel;
  logic                        wr_en;
  logic [lewc_pkg::CHAR_W-1:0] rd_val;

  assign reg_sel = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_code  <= lewc_pkg::RST_LEFT;
      right_code <= lewc_pkg::RST_RIGHT;
      up_code    <= lewc_pkg::RST_UP;
      down_code  <= lewc_pkg::RST_DOWN;
    end else if (wr_en) begin
      case (reg_sel)
        lewc_pkg::REG_LEFT:  left_code  <= pwdata[lewc_pkg::CHAR_W-1:0];
        lewc_pkg::REG_RIGHT: right_code <= pwdata[lewc_pkg::CHAR_W-1:0];
        lewc_pkg::REG_UP:    up_code    <= pwdata[lewc_pkg::CHAR_W-1:0];
        default:             down_code  <= pwdata[lewc_pkg::CHAR_W-1:0];
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      lewc_pkg::REG_LEFT:  rd_val = left_code;
      lewc_pkg::REG_RIGHT: rd_val = right_code;
      lewc_pkg::REG_UP:    rd_val = up_code;
      default:             rd_val = down_code;
    endcase
    prdata = {{(lewc_pkg::DATA_W - lewc_pkg::CHAR_W){1'b0}}, rd_val};
  end

  // enter wins over backspace, which wins over the arrows in list order
  always_comb begin
    if (key_code == lewc_pkg::CH_NL)
      kind = lewc_pkg::KEY_ENTER;
    else if (key_code == lewc_pkg::CH_BS)
      kind = lewc_pkg::KEY_BS;
    else if (key_code == left_code)
      kind = lewc_pkg::KEY_LEFT;
    else if (key_code == right_code)
      kind = lewc_pkg::KEY_RIGHT;
    else if (key_code == up_code || key_code == down_code)
      kind = lewc_pkg::KEY_IGNORE;
    else
      kind = lewc_pkg::KEY_PRINT;
  end

endmodule
`default_nettype wire

// ----- design/line_editor_with_cursor.sv -----
// Insert-mode line editor: line store, cursor, echo and line hand-out sequencer.
// Depends on lewc_pkg and lewc_cfg.
//
//   channel   signals                                   direction
//   key       key_valid, key_ready, key_code            in
//   result    result_valid, result_ready, move_before..last  out
//   config    psel, penable, pwrite, paddr, pwdata, prdata, pready  in/out
//
// The line store is a one-write, one-read memory with a registered read; each stored
// character takes a read step, then a write-and-emit step. Insert walks from the cursor
// to the line end; backspace walks the tail, then a closing step; enter emits the
// newline, then hands out the line. Arrows take a move step, ignored keys none; a
// result stall holds the sequencer. key_ready is high only while the sequencer is idle.
// Synchronous reset clears length, cursor and the sequencer; the store needs no clearing.
`default_nettype none
module line_editor_with_cursor #(
  parameter int LINE_MAX = 63
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        key_valid,
  output logic                             key_ready,
  input  wire logic [lewc_pkg::CHAR_W-1:0] key_code,
  output logic                             result_valid,
  input  wire logic                        result_ready,
  output logic signed [lewc_pkg::MOVE_W-1:0] move_before,
  output logic                             echo_valid,
  output logic      [lewc_pkg::CHAR_W-1:0] echo_char,
  output logic signed [lewc_pkg::MOVE_W-1:0] move_after,
  output logic                             line_valid,
  output logic      [lewc_pkg::CHAR_W-1:0] line_char,
  output logic                             line_end,
  output logic                             last,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lewc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [lewc_pkg::DATA_W-1:0] pwdata,
  output logic      [lewc_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);

  localparam int CW = $clog2(LINE_MAX + 1);
  localparam int AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
  localparam int MW = lewc_pkg::MOVE_W;
  localparam int DW = lewc_pkg::CHAR_W;

  lewc_pkg::lewc_key_t   kind;
  lewc_pkg::lewc_state_t state, state_next;

  logic [CW-1:0] len, len_next;
  logic [CW-1:0] cur, cur_next;
  logic [CW-1:0] pos, pos_next;
  logic [CW-1:0] pos_inc;
  logic [CW-1:0] tail;
  logic [DW-1:0] carry, carry_next;
  logic [MW-1:0] head, head_next;

  logic [DW-1:0] mem [LINE_MAX];
  logic [DW-1:0] rdata;
  logic          mem_re;
  logic          mem_we;
  logic [CW-1:0] rd_pos;
  logic [DW-1:0] wr_data;

  logic          go;
  logic          emit;
  logic          fin;
  logic [MW-1:0] e_mb;
  logic          e_ev;
  logic [DW-1:0] e_ec;
  logic [MW-1:0] e_ma;
  logic          e_lv;
  logic [DW-1:0] e_lc;
  logic          e_le;
  logic          e_last;

  lewc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .key_code (key_code),
    .kind     (kind)
  );

  assign pready    = 1'b1;
  assign key_ready = (state == lewc_pkg::ST_IDLE);
  assign go        = !result_valid || result_ready;
  assign pos_inc   = pos + CW'(1);
  assign tail      = len - cur;

  always_ff @(posedge clk) begin
    if (mem_we) mem[pos[AW-1:0]] <= wr_data;
    if (mem_re) rdata <= mem[rd_pos[AW-1:0]];
  end

  always_comb begin
    state_next = state;
    len_next   = len;
    cur_next   = cur;
    pos_next   = pos;
    carry_next = carry;
    head_next  = head;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    rd_pos     = pos;
    wr_data    = carry;
    emit       = 1'b0;
    fin        = 1'b0;
    e_mb       = lewc_pkg::MOVE_NONE;
    e_ev       = 1'b0;
    e_ec       = '0;
    e_ma       = lewc_pkg::MOVE_NONE;
    e_lv       = 1'b0;
    e_lc       = '0;
    e_le       = 1'b0;
    e_last     = 1'b0;
    case (state)
      lewc_pkg::ST_IDLE: begin
        if (key_valid) begin
          case (kind)
            lewc_pkg::KEY_ENTER: state_next = lewc_pkg::ST_NL;
            lewc_pkg::KEY_BS: begin
              if (cur != '0) begin
                cur_next   = cur - CW'(1);
                len_next   = len - CW'(1);
                pos_next   = cur - CW'(1);
                state_next = (cur < len) ? lewc_pkg::ST_BS_RD : lewc_pkg::ST_BS_END;
              end
            end
            lewc_pkg::KEY_LEFT: begin
              if (cur != '0) begin
                cur_next   = cur - CW'(1);
                head_next  = lewc_pkg::MOVE_BACK;
                state_next = lewc_pkg::ST_MOVE;
              end
            end
            lewc_pkg::KEY_RIGHT: begin
              if (cur < len) begin
                cur_next   = cur + CW'(1);
                head_next  = lewc_pkg::MOVE_FWD;
                state_next = lewc_pkg::ST_MOVE;
              end
            end
            lewc_pkg::KEY_PRINT: begin
              if (len < CW'(LINE_MAX)) begin
                carry_next = key_code;
                pos_next   = cur;
                state_next = lewc_pkg::ST_INS_RD;
              end
            end
            default: state_next = lewc_pkg::ST_IDLE;
          endcase
        end
      end
      lewc_pkg::ST_MOVE: begin
        emit   = 1'b1;
        e_mb   = head;
        e_last = 1'b1;
        if (go) state_next = lewc_pkg::ST_IDLE;
      end
      lewc_pkg::ST_INS_RD: begin
        mem_re     = 1'b1;
        state_next = lewc_pkg::ST_INS_WR;
      end
      lewc_pkg::ST_INS_WR: begin
        // shift the old character right by carrying it one place on
        fin    = (pos == len);
        emit   = 1'b1;
        e_ev   = 1'b1;
        e_ec   = carry;
        e_ma   = fin ? MW'(0) - MW'(tail) : lewc_pkg::MOVE_NONE;
        e_last = fin;
        if (go) begin
          mem_we     = 1'b1;
          carry_next = rdata;
          if (fin) begin
            len_next   = len + CW'(1);
            cur_next   = cur + CW'(1);
            state_next = lewc_pkg::ST_IDLE;
          end else begin
            pos_next   = pos_inc;
            state_next = lewc_pkg::ST_INS_RD;
          end
        end
      end
      lewc_pkg::ST_BS_RD: begin
        mem_re     = 1'b1;
        rd_pos     = pos_inc;
        state_next = lewc_pkg::ST_BS_WR;
      end
      lewc_pkg::ST_BS_WR: begin
        emit    = 1'b1;
        e_mb    = (pos == cur) ? lewc_pkg::MOVE_BACK : lewc_pkg::MOVE_NONE;
        e_ev    = 1'b1;
        e_ec    = rdata;
        wr_data = rdata;
        if (go) begin
          mem_we     = 1'b1;
          pos_next   = pos_inc;
          state_next = (pos_inc < len) ? lewc_pkg::ST_BS_RD : lewc_pkg::ST_BS_END;
        end
      end
      lewc_pkg::ST_BS_END: begin
        emit   = 1'b1;
        e_mb   = (tail == '0) ? lewc_pkg::MOVE_BACK : lewc_pkg::MOVE_NONE;
        e_ev   = 1'b1;
        e_ec   = lewc_pkg::CH_SP;
        e_ma   = MW'(0) - MW'(tail) - MW'(1);
        e_last = 1'b1;
        if (go) state_next = lewc_pkg::ST_IDLE;
      end
      lewc_pkg::ST_NL: begin
        fin    = (len == '0);
        emit   = 1'b1;
        e_mb   = MW'(tail);
        e_ev   = 1'b1;
        e_ec   = lewc_pkg::CH_NL;
        e_le   = fin;
        e_last = fin;
        if (go) begin
          pos_next = '0;
          cur_next = len;
          state_next = fin ? lewc_pkg::ST_IDLE : lewc_pkg::ST_LN_RD;
        end
      end
      lewc_pkg::ST_LN_RD: begin
        mem_re     = 1'b1;
        state_next = lewc_pkg::ST_LN_WR;
      end
      lewc_pkg::ST_LN_WR: begin
        fin    = (pos_inc == len);
        emit   = 1'b1;
        e_lv   = 1'b1;
        e_lc   = rdata;
        e_le   = fin;
        e_last = fin;
        if (go) begin
          if (fin) begin
            len_next   = '0;
            cur_next   = '0;
            state_next = lewc_pkg::ST_IDLE;
          end else begin
            pos_next   = pos_inc;
            state_next = lewc_pkg::ST_LN_RD;
          end
        end
      end
      default: state_next = lewc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= lewc_pkg::ST_IDLE;
      len          <= '0;
      cur          <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      len   <= len_next;
      cur   <= cur_next;
      if (emit && go) result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    pos   <= pos_next;
    carry <= carry_next;
    head  <= head_next;
    if (emit && go) begin
      move_before <= e_mb;
      echo_valid  <= e_ev;
      echo_char   <= e_ec;
      move_after  <= e_ma;
      line_valid  <= e_lv;
      line_char   <= e_lc;
      line_end    <= e_le;
      last        <= e_last;
    end
  end

  a_cur_in_line: assert property (@(posedge clk) disable iff (rst) cur <= len)
    else $error("cursor beyond line end");
  a_len_bound: assert property (@(posedge clk) disable iff (rst) len <= CW'(LINE_MAX))
    else $error("line length beyond capacity");
  a_write_in_line: assert property (@(posedge clk) disable iff (rst) mem_we |-> pos <= len)
    else $error("store write past line end");
  a_idle_no_access: assert property (@(posedge clk) disable iff (rst)
      (state == lewc_pkg::ST_IDLE) |-> !mem_re && !mem_we && !emit)
    else $error("store access or result while idle");

endmodule
`default_nettype wire
